// ----- rtl/ilp_pkg.sv -----
// Shared types, character codes and limit tables for the integer literal parser.
package ilp_pkg;

    // Target width codes
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;
    localparam logic [1:0] WIDTH_64 = 2'd3;

    // Character codes the parser reacts to
    localparam logic [7:0] CHAR_PLUS       = 8'h2B;
    localparam logic [7:0] CHAR_MINUS      = 8'h2D;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_0          = 8'h30;
    localparam logic [7:0] CHAR_9          = 8'h39;
    localparam logic [7:0] CHAR_LC_A       = 8'h61;
    localparam logic [7:0] CHAR_LC_F       = 8'h66;
    localparam logic [7:0] CHAR_UC_A       = 8'h41;
    localparam logic [7:0] CHAR_UC_F       = 8'h46;

    localparam int ACC_W  = 64;
    localparam int PROD_W = ACC_W + 4;

    // Token phase: sign allowed, after sign, expecting the x of 0x, in digits
    typedef enum logic [3:0] {
        PH_SIGN       = 4'b0001,
        PH_AFTER_SIGN = 4'b0010,
        PH_PREFIX_X   = 4'b0100,
        PH_DIGITS     = 4'b1000
    } phase_t;

    // Per-token parse state
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic             neg;
        logic             ovf;
        logic             hex;
        logic [1:0]       width;
        phase_t           phase;
    } ilp_state_t;

    // One finished result, before sign handling
    typedef struct packed {
        logic [ACC_W-1:0] mag;
        logic             neg;
        logic             ovf;
        logic [1:0]       width;
    } ilp_result_t;

    // Decoded digit
    typedef struct packed {
        logic       valid;
        logic [3:0] val;
    } digit_t;

    function automatic logic [ACC_W-1:0] pos_limit(input logic [1:0] width);
        logic [ACC_W-1:0] lim;
        case (width)
            WIDTH_8:  lim = 64'h0000_0000_0000_00FF;
            WIDTH_16: lim = 64'h0000_0000_0000_FFFF;
            WIDTH_32: lim = 64'h0000_0000_FFFF_FFFF;
            WIDTH_64: lim = 64'hFFFF_FFFF_FFFF_FFFF;
            default:  lim = 64'h0000_0000_0000_00FF;
        endcase
        return lim;
    endfunction

    function automatic logic [ACC_W-1:0] neg_limit(input logic [1:0] width);
        logic [ACC_W-1:0] lim;
        case (width)
            WIDTH_8:  lim = 64'h0000_0000_0000_0080;
            WIDTH_16: lim = 64'h0000_0000_0000_8000;
            WIDTH_32: lim = 64'h0000_0000_8000_0000;
            WIDTH_64: lim = 64'h8000_0000_0000_0000;
            default:  lim = 64'h0000_0000_0000_0080;
        endcase
        return lim;
    endfunction

    function automatic digit_t decode_digit(input logic [7:0] c, input logic hex);
        digit_t d;
        d.valid = 1'b0;
        d.val   = 4'd0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            d.valid = 1'b1;
            d.val   = 4'(c - CHAR_0);
        end else if (hex && c >= CHAR_LC_A && c <= CHAR_LC_F) begin
            d.valid = 1'b1;
            d.val   = 4'(c - CHAR_LC_A + 8'd10);
        end else if (hex && c >= CHAR_UC_A && c <= CHAR_UC_F) begin
            d.valid = 1'b1;
            d.val   = 4'(c - CHAR_UC_A + 8'd10);
        end
        return d;
    endfunction

    // Two's complement of the magnitude when negative, truncated to the width
    function automatic logic [ACC_W-1:0] finalize(input ilp_result_t r);
        logic [ACC_W-1:0] v;
        v = r.neg ? (~r.mag + 64'd1) : r.mag;
        return v & pos_limit(r.width);
    endfunction

endpackage

// ----- rtl/integer_literal_parser.sv -----
// Top level of the streaming integer literal parser with a two-entry result buffer.
//
//  channel | direction | ports                                          | transfer when
//  --------+-----------+------------------------------------------------+----------------------
//  input   | in        | s_char_code s_token_start s_token_end          | s_valid & s_ready
//          |           | s_is_hex s_width_code                          |
//  result  | out       | m_value m_too_large                            | m_valid & m_ready
//
//  One character is taken per cycle while s_ready is high; its state update is a single
//  registered step (shift-add of the accumulator plus one compare against the width limit).
//  A token_end character puts its result in the result register, or in the skid entry if that is held.
//  A result register plus one skid entry hold results; s_ready drops only while both are full.
//  aresetn is synchronous, active low, and clears the parse state and both buffer entries.
module integer_literal_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_token_start,
    input  logic        s_token_end,
    input  logic        s_is_hex,
    input  logic [1:0]  s_width_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value,
    output logic        m_too_large
);
    import ilp_pkg::*;

    ilp_state_t  state_reg;
    ilp_state_t  state_next;
    ilp_state_t  step_out;
    ilp_result_t main_reg;
    ilp_result_t main_next;
    ilp_result_t skid_reg;
    ilp_result_t skid_next;
    ilp_result_t new_res;
    logic        main_valid_reg;
    logic        main_valid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    logic        in_xfer;
    logic        push;
    logic        pop;

    ilp_step u_step (
        .cur         (state_reg),
        .char_code   (s_char_code),
        .token_start (s_token_start),
        .is_hex      (s_is_hex),
        .width_code  (s_width_code),
        .nxt         (step_out)
    );

    // Handshake
    assign s_ready = !skid_valid_reg;
    assign in_xfer = s_valid && s_ready;
    assign push    = in_xfer && s_token_end;
    assign pop     = main_valid_reg && m_ready;

    // Parse state advances on every input transfer
    always_comb begin
        state_next = in_xfer ? step_out : state_reg;
    end

    // Result of the character just taken
    always_comb begin
        new_res.mag   = step_out.acc;
        new_res.neg   = step_out.neg;
        new_res.ovf   = step_out.ovf;
        new_res.width = step_out.width;
    end

    // Result register with one skid entry behind it
    always_comb begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next       = new_res;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = new_res;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.acc   <= '0;
            state_reg.neg   <= 1'b0;
            state_reg.ovf   <= 1'b0;
            state_reg.hex   <= 1'b0;
            state_reg.width <= WIDTH_8;
            state_reg.phase <= PH_SIGN;
            main_valid_reg  <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_valid     = main_valid_reg;
    assign m_value     = finalize(main_reg);
    assign m_too_large = main_reg.ovf;

`ifndef NO_ASSERTIONS
    // The skid entry is only ever filled behind a full result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid while result register empty");

    // The magnitude never passes the positive limit of the held width
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.acc <= pos_limit(state_reg.width))
        else $error("accumulator above width limit");

    // Saturation leaves the accumulator sitting at one of the limits
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.ovf |-> (state_reg.acc == pos_limit(state_reg.width) ||
                           state_reg.acc == neg_limit(state_reg.width)))
        else $error("overflow flag set without saturated accumulator");

    // After a final character, m_valid is always high on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> m_valid)
        else $error("token end transfer produced no result");

    // Input is refused only while both result entries are occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (main_valid_reg && skid_valid_reg))
        else $error("input stalled with free result space");
`endif

endmodule

// ----- rtl/ilp_step.sv -----
// Per-character next-state logic: sign, prefix skip and saturating digit accumulate.
module ilp_step (
    input  ilp_pkg::ilp_state_t cur,
    input  logic [7:0]          char_code,
    input  logic                token_start,
    input  logic                is_hex,
    input  logic [1:0]          width_code,
    output ilp_pkg::ilp_state_t nxt
);
    import ilp_pkg::*;

    ilp_state_t       base_st;
    digit_t           dig;
    logic [ACC_W-1:0] lim;
    logic [PROD_W-1:0] scaled;
    logic [PROD_W-1:0] cand;

    // A token start clears the state and samples kind and width
    always_comb begin
        base_st = cur;
        if (token_start) begin
            base_st.acc   = '0;
            base_st.neg   = 1'b0;
            base_st.ovf   = 1'b0;
            base_st.hex   = is_hex;
            base_st.width = width_code;
            base_st.phase = PH_SIGN;
        end
    end

    // acc * base + digit as shifts and adds; compare against the limit
    always_comb begin
        dig = decode_digit(char_code, base_st.hex);
        lim = base_st.neg ? neg_limit(base_st.width) : pos_limit(base_st.width);
        if (base_st.hex) begin
            scaled = {base_st.acc, 4'b0000};
        end else begin
            scaled = {1'b0, base_st.acc, 3'b000} + {3'b000, base_st.acc, 1'b0};
        end
        cand = scaled + {{(PROD_W-4){1'b0}}, dig.val};
    end

    // Character handling
    always_comb begin
        nxt = base_st;
        if (base_st.phase == PH_SIGN && (char_code == CHAR_MINUS || char_code == CHAR_PLUS)) begin
            nxt.neg   = (char_code == CHAR_MINUS);
            nxt.phase = PH_AFTER_SIGN;
        end else if (base_st.hex &&
                     (base_st.phase == PH_SIGN || base_st.phase == PH_AFTER_SIGN)) begin
            nxt.phase = PH_PREFIX_X;
        end else if (base_st.hex && base_st.phase == PH_PREFIX_X) begin
            nxt.phase = PH_DIGITS;
        end else begin
            nxt.phase = PH_DIGITS;
            if (char_code != CHAR_UNDERSCORE && dig.valid && !base_st.ovf) begin
                if (cand > {4'b0000, lim}) begin
                    nxt.acc = lim;
                    nxt.ovf = 1'b1;
                end else begin
                    nxt.acc = cand[ACC_W-1:0];
                end
            end
        end
    end

endmodule
